// ===== hdl/smudge_brush_pixel_blend_defines.svh =====
// Assertion macros for the smudge brush pixel blend checker.
`ifndef SMUDGE_BRUSH_PIXEL_BLEND_DEFINES_SVH
`define SMUDGE_BRUSH_PIXEL_BLEND_DEFINES_SVH

// Checked only while out of reset.
`define SBPB_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SBPB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sbpb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the smudge brush pixel blend.
`default_nettype none

package sbpb_pkg;

  localparam int SBPB_MAX_SIDE = 64;

  localparam int COORD_W    = 6;
  localparam int SIDE_W     = 7;
  localparam int Q_W        = 9;
  localparam int Q_FRAC     = 8;
  localparam int PIX_W      = 32;
  localparam int PROD_W     = COORD_W + SIDE_W;
  localparam int IDX_W      = PROD_W + SIDE_W + 1;
  localparam int ADDR_MAX_W = 16;
  localparam int CFG_W      = Q_W;
  localparam int CFG_IDX_W  = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [Q_W-1:0] Q_ONE = Q_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PMODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE    = 2'd3;

  typedef enum logic [1:0] {
    PM_NONE,
    PM_SIZE,
    PM_OPACITY,
    PM_FLOW
  } pmode_t;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_SAMPLE,
    KIND_SMUDGE
  } kind_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_PREP,
    FS_EFF,
    FS_ALPHA,
    FS_DIV,
    FS_INDEX,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_BLEND
  } back_state_t;

  typedef struct packed {
    logic [Q_W-1:0]    opacity;
    logic [Q_W-1:0]    flow;
    pmode_t            pressure_mode;
    logic [SIDE_W-1:0] carried_side;
  } cfg_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_MAX_W-1:0] addr;
    logic [PIX_W-1:0]      pixel;
    logic [Q_W-1:0]        t;
    logic [Q_W-1:0]        alpha;
  } qentry_t;

  function automatic logic [Q_W-1:0] sat_q8(input logic [Q_W-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

  // base + floor((toward - base) * w / 512), w in 0..512
  function automatic logic [7:0] mix8(input logic [7:0] base, input logic [7:0] toward,
                                      input logic [9:0] w);
    logic signed [8:0]  diff;
    logic signed [19:0] prod;
    logic signed [10:0] step;
    logic signed [10:0] sum;
    diff = $signed({1'b0, toward}) - $signed({1'b0, base});
    prod = diff * $signed({1'b0, w});
    step = prod[19:9];
    sum  = $signed({3'b000, base}) + step;
    return sum[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smudge_brush_pixel_blend.sv =====
// Smudge brush pixel blend top level: config registers, front end, queue, back end.
// Samples and zero-alpha smudges go straight to the queue; other smudges work out weight and
// index, and those with scaled sides also use the coordinate divider in the front end.
// Busy clears once the front end has queued the item; the back end finishes each item's store
// read-modify-write before it pops the next one. Results cannot be stalled.
// Reset: config to defaults, then a clearing pass over all MAX_SIDE*MAX_SIDE store words with busy high.
`default_nettype none

module smudge_brush_pixel_blend import sbpb_pkg::*; #(
  parameter int MAX_SIDE = SBPB_MAX_SIDE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [COORD_W-1:0]   in_col,
  input  logic [COORD_W-1:0]   in_row,
  input  logic [SIDE_W-1:0]    in_stamp_side,
  input  logic [Q_W-1:0]       in_brush_alpha,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic [Q_W-1:0]       in_pressure,
  output logic                 out_valid,
  output logic [PIX_W-1:0]     out_new_pixel,
  output logic                 out_written,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t    cfg_r;
  logic    front_idle, clearing, accept;
  logic    q_push, q_pop, q_full, q_empty;
  qentry_t q_wdata, q_head;

  assign busy   = clearing || !front_idle;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.opacity       <= Q_ONE;
      cfg_r.flow          <= Q_ONE;
      cfg_r.pressure_mode <= PM_NONE;
      cfg_r.carried_side  <= SIDE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPACITY: cfg_r.opacity       <= cfg_wdata;
        CFG_FLOW:    cfg_r.flow          <= cfg_wdata;
        CFG_PMODE:   cfg_r.pressure_mode <= pmode_t'(cfg_wdata[1:0]);
        CFG_SIDE:    cfg_r.carried_side  <= cfg_wdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  sbpb_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .command     (in_command),
    .col         (in_col),
    .row         (in_row),
    .stamp_side  (in_stamp_side),
    .brush_alpha (in_brush_alpha),
    .pixel       (in_pixel),
    .pressure    (in_pressure),
    .q_full      (q_full),
    .idle        (front_idle),
    .push        (q_push),
    .entry       (q_wdata)
  );

  sbpb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  sbpb_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .head          (q_head),
    .pop           (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_new_pixel (out_new_pixel),
    .out_written   (out_written)
  );

endmodule

`default_nettype wire

// ===== hdl/sbpb_div.sv =====
// Two-lane restoring divider for stamp coordinate scaling, one quotient bit per cycle.
`default_nettype none

module sbpb_div import sbpb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num_x,
  input  logic [PROD_W-1:0] num_y,
  input  logic [SIDE_W-1:0] den,
  output logic              busy,
  output logic [PROD_W-1:0] quo_x,
  output logic [PROD_W-1:0] quo_y
);

  localparam int CNT_W = $clog2(PROD_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SIDE_W-1:0] den_r;
  logic [PROD_W-1:0] quo_r [2];
  logic [SIDE_W-1:0] rem_r [2];
  logic [PROD_W-1:0] quo_nxt [2];
  logic [SIDE_W-1:0] rem_nxt [2];

  always_comb begin
    logic [SIDE_W:0] trial;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_r[i], quo_r[i][PROD_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt[i] = SIDE_W'(trial - {1'b0, den_r});
        quo_nxt[i] = {quo_r[i][PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[SIDE_W-1:0];
        quo_nxt[i] = {quo_r[i][PROD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r    <= den;
      quo_r[0] <= num_x;
      quo_r[1] <= num_y;
      rem_r[0] <= '0;
      rem_r[1] <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy  = busy_r;
  assign quo_x = quo_r[0];
  assign quo_y = quo_r[1];

endmodule

`default_nettype wire

// ===== hdl/sbpb_front.sv =====
// Front end: takes an item, classifies it, works out blend weight and store address.
`default_nettype none

module sbpb_front import sbpb_pkg::*; #(
  parameter int MAX_SIDE = SBPB_MAX_SIDE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               accept,
  input  logic               command,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  logic [SIDE_W-1:0]  stamp_side,
  input  logic [Q_W-1:0]     brush_alpha,
  input  logic [PIX_W-1:0]   pixel,
  input  logic [Q_W-1:0]     pressure,
  input  logic               q_full,
  output logic               idle,
  output logic               push,
  output qentry_t            entry
);

  localparam logic [SIDE_W+1:0] MAX_SIDE_V = (SIDE_W + 2)'(MAX_SIDE);

  front_state_t state_r, state_nxt;

  logic               cmd_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic [SIDE_W-1:0]  ss_r;
  logic [Q_W-1:0]     alpha_r, pr_r;
  logic [PIX_W-1:0]   pix_r;
  logic [Q_W-1:0]     s_r, f_r, e_r, t_r;
  logic [PROD_W-1:0]  prod_x_r, prod_y_r, eq_idx_r;
  logic               scaled_r;
  kind_t              kind_r;
  logic [ADDR_MAX_W-1:0] addr_r;

  logic [SIDE_W-1:0]  cs;
  logic [Q_W-1:0]     s0, f0, pm_a, pm_q;
  logic [2*Q_W-1:0]   pm_p, e_p, t_p;
  logic [PROD_W-1:0]  prod_x, prod_y, eq_idx;
  logic [IDX_W-1:0]   idx, lim;
  logic               div_start, div_busy;
  logic [PROD_W-1:0]  quo_x, quo_y;

  // carried side saturated to 1..MAX_SIDE
  always_comb begin
    if (cfg.carried_side == '0) cs = SIDE_W'(1);
    else if ({2'b00, cfg.carried_side} > MAX_SIDE_V) cs = MAX_SIDE_V[SIDE_W-1:0];
    else cs = cfg.carried_side;
  end

  assign s0     = sat_q8(cfg.opacity);
  assign f0     = sat_q8(cfg.flow);
  assign pm_a   = (cfg.pressure_mode == PM_FLOW) ? f0 : s0;
  assign pm_p   = pm_a * pr_r;
  assign pm_q   = pm_p[Q_FRAC+Q_W-1:Q_FRAC];
  assign e_p    = s_r * f_r;
  assign t_p    = e_r * alpha_r;
  assign prod_x = PROD_W'(col_r) * PROD_W'(cs);
  assign prod_y = PROD_W'(row_r) * PROD_W'(cs);
  assign eq_idx = prod_y + PROD_W'(col_r);
  assign lim    = IDX_W'(cs) * IDX_W'(cs);
  assign idx    = scaled_r ? (IDX_W'(quo_y) * IDX_W'(cs) + IDX_W'(quo_x))
                           : IDX_W'(eq_idx_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE:  if (accept) state_nxt = FS_PREP;
      FS_PREP:  state_nxt = (!cmd_r || alpha_r == '0) ? FS_PUSH : FS_EFF;
      FS_EFF:   state_nxt = FS_ALPHA;
      FS_ALPHA: state_nxt = scaled_r ? FS_DIV : FS_INDEX;
      FS_DIV:   if (!div_busy) state_nxt = FS_INDEX;
      FS_INDEX: state_nxt = FS_PUSH;
      FS_PUSH:  if (!q_full) state_nxt = FS_IDLE;
      default:  state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    idle      = (state_r == FS_IDLE);
    div_start = (state_r == FS_EFF) && scaled_r;
    push      = (state_r == FS_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FS_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= command;
      col_r   <= col;
      row_r   <= row;
      ss_r    <= (stamp_side == '0) ? SIDE_W'(1) : stamp_side;
      alpha_r <= sat_q8(brush_alpha);
      pix_r   <= pixel;
      pr_r    <= sat_q8(pressure);
    end
    case (state_r)
      FS_PREP: begin
        s_r      <= (cfg.pressure_mode == PM_OPACITY) ? pm_q : s0;
        f_r      <= (cfg.pressure_mode == PM_FLOW) ? pm_q : f0;
        prod_x_r <= prod_x;
        prod_y_r <= prod_y;
        eq_idx_r <= eq_idx;
        scaled_r <= (ss_r != cs);
        addr_r   <= ADDR_MAX_W'(eq_idx);
        if (!cmd_r) begin
          kind_r <= ({1'b0, col_r} < cs && {1'b0, row_r} < cs) ? KIND_SAMPLE : KIND_SKIP;
        end else begin
          kind_r <= (alpha_r == '0) ? KIND_SKIP : KIND_SMUDGE;
        end
      end
      FS_EFF:   e_r <= e_p[Q_FRAC+Q_W-1:Q_FRAC];
      FS_ALPHA: t_r <= t_p[Q_FRAC+Q_W-1:Q_FRAC];
      FS_INDEX: begin
        addr_r <= idx[ADDR_MAX_W-1:0];
        if (idx >= lim) kind_r <= KIND_SKIP;
      end
      default: ;
    endcase
  end

  sbpb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_x (prod_x_r),
    .num_y (prod_y_r),
    .den   (ss_r),
    .busy  (div_busy),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  always_comb begin
    entry.kind  = kind_r;
    entry.addr  = addr_r;
    entry.pixel = pix_r;
    entry.t     = t_r;
    entry.alpha = alpha_r;
  end

endmodule

`default_nettype wire

// ===== hdl/sbpb_queue.sv =====
// Short FIFO carrying classified items from the front end to the back end.
`default_nettype none

module sbpb_queue import sbpb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t wdata,
  input  logic    pop,
  output qentry_t head,
  output logic    full,
  output logic    empty
);

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  qentry_t            entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

// ===== hdl/sbpb_back.sv =====
// Back end: carried color store, read-modify-write blend and result register.
`default_nettype none

module sbpb_back import sbpb_pkg::*; #(
  parameter int MAX_SIDE = SBPB_MAX_SIDE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  qentry_t          head,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_new_pixel,
  output logic             out_written
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  back_state_t state_r, state_nxt;

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rdata_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  qentry_t           cur_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, rd_addr;
  logic [PIX_W-1:0]  mem_wdata;
  logic [PIX_W-1:0]  np, nc;

  logic              out_valid_r, out_written_r;
  logic [PIX_W-1:0]  out_new_pixel_r;

  assign rd_addr = head.addr[ADDR_W-1:0];

  // per channel: pixel moves toward carried by t, carried toward pixel by alpha/2
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      np[8*ch +: 8] = mix8(cur_r.pixel[8*ch +: 8], rdata_r[8*ch +: 8], {cur_r.t, 1'b0});
      nc[8*ch +: 8] = mix8(rdata_r[8*ch +: 8], cur_r.pixel[8*ch +: 8], {1'b0, cur_r.alpha});
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = BS_IDLE;
      BS_IDLE:  if (!q_empty) state_nxt = BS_BLEND;
      BS_BLEND: state_nxt = BS_IDLE;
      default:  state_nxt = BS_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = 1'b0;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur_r.addr[ADDR_W-1:0];
    mem_wdata = nc;
    case (state_r)
      BS_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      BS_IDLE: pop = !q_empty;
      BS_BLEND: begin
        mem_we    = (cur_r.kind != KIND_SKIP);
        mem_wdata = (cur_r.kind == KIND_SAMPLE) ? cur_r.pixel : nc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BS_CLEAR;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      out_written_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= (state_r == BS_BLEND);
      out_written_r <= (state_r == BS_BLEND) && (cur_r.kind == KIND_SMUDGE);
      if (state_r == BS_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
    if (state_r == BS_BLEND) out_new_pixel_r <= (cur_r.kind == KIND_SMUDGE) ? np : '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_written   = out_written_r;
  assign out_new_pixel = out_new_pixel_r;

endmodule

`default_nettype wire

// ===== hdl/sbpb_checker.sv =====
// Port-level checker for the smudge brush pixel blend, bound to the top level.
`default_nettype none
`include "smudge_brush_pixel_blend_defines.svh"

module sbpb_checker import sbpb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [PIX_W-1:0] out_new_pixel,
  input logic             out_written
);

  // reset always starts the store clearing pass
  `SBPB_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> busy, "busy low right after reset")

  `SBPB_ASSERT_RUN(a_accept_busy, (start && !busy) |=> busy, "busy low after a transfer")

  // back end reads the store and then writes it back for each item
  `SBPB_ASSERT_RUN(a_strobe_gap, out_valid |=> !out_valid, "results on consecutive cycles")

  `SBPB_ASSERT_RUN(a_written_valid, out_written |-> out_valid, "written without a result")

  `SBPB_ASSERT_RUN(a_unwritten_zero, (out_valid && !out_written) |-> (out_new_pixel == '0),
                   "unwritten result carries a pixel")

endmodule

bind smudge_brush_pixel_blend sbpb_checker u_sbpb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_new_pixel (out_new_pixel),
  .out_written   (out_written)
);

`default_nettype wire

// ===== test/smudge_brush_pixel_blend_checker.sv =====
// Checker for the smudge brush pixel blend: tracks config and carried colors, checks each result.
`timescale 1ns / 100ps

module smudge_brush_pixel_blend_checker import sbpb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_command,
  input  logic [COORD_W-1:0]   in_col,
  input  logic [COORD_W-1:0]   in_row,
  input  logic [SIDE_W-1:0]    in_stamp_side,
  input  logic [Q_W-1:0]       in_brush_alpha,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic [Q_W-1:0]       in_pressure,
  input  logic                 out_valid,
  input  logic [PIX_W-1:0]     out_new_pixel,
  input  logic                 out_written,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   outstanding
);

  localparam int STORE_DEPTH = SBPB_MAX_SIDE * SBPB_MAX_SIDE;

  typedef struct packed {
    logic [PIX_W-1:0] new_pixel;
    logic             written;
  } blend_result_t;

  logic [PIX_W-1:0] carried_color [STORE_DEPTH];
  logic [Q_W-1:0]   opacity_r;
  logic [Q_W-1:0]   flow_r;
  pmode_t           pmode_r;
  logic [SIDE_W-1:0] side_r;
  blend_result_t    expected_pixels [$];
  int               fail_cnt;

  initial begin
    errors = 0;
    outstanding = 0;
    fail_cnt = 0;
  end

  function automatic int unsigned clamp_q8(input int unsigned v);
    return (v > 256) ? 256 : v;
  endfunction

  // Works out one item's result and updates the carried colors as the block does.
  function automatic blend_result_t smudge_pixel(input logic is_smudge,
                                                 input int unsigned col,
                                                 input int unsigned row,
                                                 input int unsigned stamp_side,
                                                 input int unsigned alpha_raw,
                                                 input logic [PIX_W-1:0] pix,
                                                 input int unsigned pressure_raw);
    int unsigned   side, alpha, pr, ss, idx, s, f, e, t, cc, dd, sh;
    logic [PIX_W-1:0] carried, np, nc;
    blend_result_t res;
    res = '0;
    np = '0;
    nc = '0;
    side = side_r;
    if (side < 1) side = 1;
    if (side > SBPB_MAX_SIDE) side = SBPB_MAX_SIDE;
    alpha = clamp_q8(alpha_raw);
    pr = clamp_q8(pressure_raw);
    if (!is_smudge) begin
      if (col < side && row < side) carried_color[row * side + col] = pix;
      return res;
    end
    if (alpha == 0) return res;
    ss = (stamp_side == 0) ? 1 : stamp_side;
    if (ss == side) begin
      idx = row * side + col;
    end else begin
      idx = (row * side / ss) * side + col * side / ss;
    end
    if (idx >= side * side) return res;
    s = clamp_q8(opacity_r);
    f = clamp_q8(flow_r);
    if (pmode_r == PM_OPACITY) s = (s * pr) >> 8;
    else if (pmode_r == PM_FLOW) f = (f * pr) >> 8;
    e = (s * f) >> 8;
    t = (e * alpha) >> 8;
    carried = carried_color[idx];
    for (sh = 0; sh < PIX_W; sh += 8) begin
      cc = carried[sh +: 8];
      dd = pix[sh +: 8];
      np[sh +: 8] = 8'((dd * (256 - t) + cc * t) >> 8);
      nc[sh +: 8] = 8'((cc * (512 - alpha) + dd * alpha) >> 9);
    end
    carried_color[idx] = nc;
    res.new_pixel = np;
    res.written = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    blend_result_t want;
    if (!rst_n) begin
      opacity_r = Q_ONE;
      flow_r = Q_ONE;
      pmode_r = PM_NONE;
      side_r = SIDE_W'(1);
      for (int i = 0; i < STORE_DEPTH; i++) carried_color[i] = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OPACITY: opacity_r = cfg_wdata;
          CFG_FLOW:    flow_r = cfg_wdata;
          CFG_PMODE:   pmode_r = pmode_t'(cfg_wdata[1:0]);
          CFG_SIDE:    side_r = cfg_wdata[SIDE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result new_pixel=%h written=%b", $time,
                     out_new_pixel, out_written);
        end else begin
          want = expected_pixels.pop_front();
          if (out_new_pixel !== want.new_pixel || out_written !== want.written) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch new_pixel exp %h got %h, written exp %b got %b",
                       $time, want.new_pixel, out_new_pixel, want.written, out_written);
          end
        end
      end
      if (start && !busy)
        expected_pixels.push_back(smudge_pixel(in_command, in_col, in_row, in_stamp_side,
                                               in_brush_alpha, in_pixel, in_pressure));
    end
    errors <= fail_cnt;
    outstanding <= expected_pixels.size();
  end

endmodule

// ===== test/smudge_brush_pixel_blend_test.sv =====
// Testbench top for the smudge brush pixel blend: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module smudge_brush_pixel_blend_test;
  import sbpb_pkg::*;

  localparam int  CYCLE_LIMIT  = 250000;
  localparam int  PHASE_ITEMS  = 110;
  localparam int  NUM_PHASES   = 8;
  localparam int  SETTLE_CYCLES = 30;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_SMUDGE = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_command = CMD_SAMPLE;
  logic [COORD_W-1:0]   in_col = '0;
  logic [COORD_W-1:0]   in_row = '0;
  logic [SIDE_W-1:0]    in_stamp_side = SIDE_W'(1);
  logic [Q_W-1:0]       in_brush_alpha = '0;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic [Q_W-1:0]       in_pressure = '0;
  logic                 out_valid;
  logic [PIX_W-1:0]     out_new_pixel;
  logic                 out_written;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_OPACITY;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int          errors;
  int          outstanding;
  int          cycles = 0;
  int unsigned side_eff = 1;
  bit          no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  smudge_brush_pixel_blend DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_stamp_side  (in_stamp_side),
    .in_brush_alpha (in_brush_alpha),
    .in_pixel       (in_pixel),
    .in_pressure    (in_pressure),
    .out_valid      (out_valid),
    .out_new_pixel  (out_new_pixel),
    .out_written    (out_written),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  smudge_brush_pixel_blend_checker blend_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_stamp_side  (in_stamp_side),
    .in_brush_alpha (in_brush_alpha),
    .in_pixel       (in_pixel),
    .in_pressure    (in_pressure),
    .out_valid      (out_valid),
    .out_new_pixel  (out_new_pixel),
    .out_written    (out_written),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .errors         (errors),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Start stays high into the next item; a gap lowers it only after the transfer.
  task automatic send_item(input logic cmd, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [SIDE_W-1:0] ss,
                           input logic [Q_W-1:0] alpha, input logic [PIX_W-1:0] pix,
                           input logic [Q_W-1:0] pr);
    start          <= 1'b1;
    in_command     <= cmd;
    in_col         <= col;
    in_row         <= row;
    in_stamp_side  <= ss;
    in_brush_alpha <= alpha;
    in_pixel       <= pix;
    in_pressure    <= pr;
    do @(posedge clk); while (busy);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned op, input int unsigned fl, input pmode_t pm,
                            input int unsigned side);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OPACITY;
    cfg_wdata <= CFG_W'(op);
    @(posedge clk);
    cfg_index <= CFG_FLOW;
    cfg_wdata <= CFG_W'(fl);
    @(posedge clk);
    cfg_index <= CFG_PMODE;
    cfg_wdata <= CFG_W'(pm);
    @(posedge clk);
    cfg_index <= CFG_SIDE;
    cfg_wdata <= CFG_W'(side);
    @(posedge clk);
    cfg_we <= 1'b0;
    side_eff = (side == 0) ? 1 : (side > SBPB_MAX_SIDE) ? SBPB_MAX_SIDE : side;
  endtask

  // Mostly in-store samples and smudges at the carried side, with some noise.
  task automatic random_item();
    logic             cmd;
    logic [COORD_W-1:0] col, row;
    logic [SIDE_W-1:0]  ss;
    logic [Q_W-1:0]     alpha, pr;
    int unsigned        bound;
    cmd = ($urandom_range(0, 9) >= 4) ? CMD_SMUDGE : CMD_SAMPLE;
    case ($urandom_range(0, 9))
      0:       ss = SIDE_W'($urandom);
      1, 2:    ss = SIDE_W'($urandom_range(1, SBPB_MAX_SIDE));
      default: ss = SIDE_W'(side_eff);
    endcase
    bound = (cmd == CMD_SMUDGE && ss >= 1 && ss <= SBPB_MAX_SIDE) ? ss : side_eff;
    if ($urandom_range(0, 9) == 0) begin
      col = COORD_W'($urandom);
      row = COORD_W'($urandom);
    end else begin
      col = COORD_W'($urandom_range(0, bound - 1));
      row = COORD_W'($urandom_range(0, bound - 1));
    end
    case ($urandom_range(0, 15))
      0:       alpha = '0;
      1:       alpha = Q_W'($urandom_range(257, 511));
      2:       alpha = Q_ONE;
      default: alpha = Q_W'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 15))
      0:       pr = Q_W'($urandom_range(257, 511));
      1:       pr = '0;
      2:       pr = Q_ONE;
      default: pr = Q_W'($urandom_range(0, 255));
    endcase
    send_item(cmd, col, row, ss, alpha, $urandom, pr);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // store clearing pass after reset
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    set_config(256, 256, PM_OPACITY, 8);
    send_item(CMD_SAMPLE, 0, 0, 8, 256, 32'hFFFFFFFF, 256);
    send_item(CMD_SAMPLE, 7, 7, 8, 256, 32'h80402010, 256);
    send_item(CMD_SAMPLE, 8, 2, 8, 256, 32'h11111111, 256);   // outside the store
    send_item(CMD_SAMPLE, 63, 63, 8, 256, 32'h22222222, 256);
    send_item(CMD_SMUDGE, 0, 0, 8, 256, 32'h00000000, 256);
    send_item(CMD_SMUDGE, 0, 0, 8, 0, 32'h12345678, 256);     // zero alpha skips
    send_item(CMD_SMUDGE, 7, 7, 8, 511, 32'hFFFFFFFF, 511);
    send_item(CMD_SMUDGE, 7, 7, 8, 128, 32'h00FF00FF, 0);
    send_item(CMD_SMUDGE, 63, 63, 8, 256, 32'hA5A5A5A5, 256); // index past the store
    send_item(CMD_SMUDGE, 15, 15, 16, 200, 32'h5A5A5A5A, 256);
    send_item(CMD_SMUDGE, 1, 1, 4, 100, 32'hDEADBEEF, 128);
    send_item(CMD_SMUDGE, 3, 3, 0, 256, 32'h01020304, 256);   // stamp side zero
    send_item(CMD_SMUDGE, 63, 0, 127, 256, 32'hF0F0F0F0, 256);
    send_item(CMD_SMUDGE, 0, 63, 64, 256, 32'h0F0F0F0F, 300);
    send_item(CMD_SMUDGE, 5, 2, 8, 1, 32'h7F7F7F7F, 128);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: set_config(128, 200, PM_OPACITY, 64);
          2: set_config(511, 511, PM_FLOW, 1);
          3: set_config(0, 256, PM_SIZE, 16);
          4: set_config(256, 0, PM_OPACITY, 0);
          5: set_config($urandom_range(0, 511), $urandom_range(0, 511), PM_FLOW, 127);
          6: set_config($urandom_range(0, 511), $urandom_range(0, 511),
                        pmode_t'($urandom_range(0, 3)), $urandom_range(1, 64));
          default: set_config($urandom_range(0, 256), $urandom_range(0, 256), PM_NONE, 4);
        endcase
      end
      no_gaps = (p == NUM_PHASES - 1);
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
